// ===== rtl/core/lcr_pkg.sv =====
package lcr_pkg;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TAKE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        CMD_NONE      = 2'd0,
        CMD_CALIBRATE = 2'd1,
        CMD_PING      = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_UNKNOWN  = 2'd1,
        ERR_TOO_LONG = 2'd2
    } err_t;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam int unsigned CAL_LEN  = 9;
    localparam int unsigned PING_LEN = 4;

    // Letter of "CALIBRATE" at a position below CAL_LEN.
    function automatic logic [7:0] cal_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "C";
            4'd1:    c = "A";
            4'd2:    c = "L";
            4'd3:    c = "I";
            4'd4:    c = "B";
            4'd5:    c = "R";
            4'd6:    c = "A";
            4'd7:    c = "T";
            4'd8:    c = "E";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] ping_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = "P";
            2'd1:    c = "I";
            2'd2:    c = "N";
            2'd3:    c = "G";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/lcr_if.sv =====
interface lcr_rx_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] rx_data;

    modport source (output valid, output opcode, output rx_data, input ready);
    modport sink (input valid, input opcode, input rx_data, output ready);
endinterface

interface lcr_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] error_code;
    logic [1:0] taken_command;

    modport source (output valid, output error_code, output taken_command, input ready);
    modport sink (input valid, input error_code, input taken_command, output ready);
endinterface

// ===== rtl/core/line_command_recognizer.sv =====
// Line command recognizer. Each word on rx is either a received byte or a take request.
// Bytes build a line that CR or LF ends; a line of exactly CALIBRATE or PING becomes the
// pending command, any other non-empty line gives error_code 1, and a line that would reach
// LINE_CAPACITY bytes is dropped with error_code 2. A take returns the pending command and
// clears it. Every accepted word gives exactly one result word in the next cycle, and a new
// word is accepted every cycle; the single result register is the only stage, so rx stalls
// only while a result waits on result.ready.
module line_command_recognizer #(
    parameter int unsigned LINE_CAPACITY = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    lcr_rx_if.sink               rx,
    lcr_result_if.source         result
);

    localparam int unsigned LenW = $clog2(LINE_CAPACITY);
    localparam logic [LenW-1:0] LEN_LAST = LenW'(LINE_CAPACITY - 1);
    localparam logic [LenW-1:0] LEN_CAL  = LenW'(lcr_pkg::CAL_LEN);
    localparam logic [LenW-1:0] LEN_PING = LenW'(lcr_pkg::PING_LEN);

    logic [LenW-1:0]   line_length_reg, line_length_next;
    logic              match_cal_reg, match_cal_next;
    logic              match_ping_reg, match_ping_next;
    lcr_pkg::cmd_t     pending_reg, pending_next;
    logic              out_valid_reg;
    lcr_pkg::err_t     error_reg, error_next;
    lcr_pkg::cmd_t     taken_reg, taken_next;

    logic accept;
    logic is_term;

    assign rx.ready = !out_valid_reg || result.ready;
    assign accept   = rx.valid && rx.ready;
    assign is_term  = (rx.rx_data == lcr_pkg::CHAR_CR) || (rx.rx_data == lcr_pkg::CHAR_LF);

    always_comb
    begin
        line_length_next = line_length_reg;
        match_cal_next   = match_cal_reg;
        match_ping_next  = match_ping_reg;
        pending_next     = pending_reg;
        error_next       = lcr_pkg::ERR_NONE;
        taken_next       = lcr_pkg::CMD_NONE;

        if (lcr_pkg::op_t'(rx.opcode) == lcr_pkg::OP_TAKE)
        begin
            taken_next   = pending_reg;
            pending_next = lcr_pkg::CMD_NONE;
        end
        else if (is_term)
        begin
            // An empty line sets no command and no error.
            if (line_length_reg != '0)
            begin
                if (match_cal_reg && line_length_reg == LEN_CAL)
                    pending_next = lcr_pkg::CMD_CALIBRATE;
                else if (match_ping_reg && line_length_reg == LEN_PING)
                    pending_next = lcr_pkg::CMD_PING;
                else
                    error_next = lcr_pkg::ERR_UNKNOWN;
                line_length_next = '0;
                match_cal_next   = 1'b1;
                match_ping_next  = 1'b1;
            end
        end
        else if (line_length_reg < LEN_LAST)
        begin
            match_cal_next = match_cal_reg && (line_length_reg < LEN_CAL)
                && (lcr_pkg::cal_char(line_length_reg[3:0]) == rx.rx_data);
            match_ping_next = match_ping_reg && (line_length_reg < LEN_PING)
                && (lcr_pkg::ping_char(line_length_reg[1:0]) == rx.rx_data);
            line_length_next = line_length_reg + 1'b1;
        end
        else
        begin
            line_length_next = '0;
            match_cal_next   = 1'b1;
            match_ping_next  = 1'b1;
            error_next       = lcr_pkg::ERR_TOO_LONG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= '0;
            match_cal_reg   <= 1'b1;
            match_ping_reg  <= 1'b1;
            pending_reg     <= lcr_pkg::CMD_NONE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                line_length_reg <= line_length_next;
                match_cal_reg   <= match_cal_next;
                match_ping_reg  <= match_ping_next;
                pending_reg     <= pending_next;
                out_valid_reg   <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            error_reg <= error_next;
            taken_reg <= taken_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.error_code    = error_reg;
    assign result.taken_command = taken_reg;

endmodule

// ===== rtl/core/lcr_checker.sv =====
module lcr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rx_valid,
    input logic       rx_ready,
    input logic       rx_opcode,
    input logic       res_valid,
    input logic       res_ready,
    input logic [1:0] res_error_code,
    input logic [1:0] res_taken_command
);

    logic rx_acc;
    logic take_acc;

    assign rx_acc   = rx_valid && rx_ready;
    assign take_acc = rx_acc && (lcr_pkg::op_t'(rx_opcode) == lcr_pkg::OP_TAKE);

    // A result that is not taken stays put.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_error_code)
            && $stable(res_taken_command))
        else $error("result word changed while stalled");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        rx_acc |=> res_valid)
        else $error("accepted word produced no result");

    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_error_code == lcr_pkg::ERR_NONE)
            || (res_taken_command == lcr_pkg::CMD_NONE))
        else $error("result carries both an error and a command");

    // The second of two back-to-back takes finds nothing pending.
    a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take_acc ##1 take_acc |=> res_taken_command == lcr_pkg::CMD_NONE)
        else $error("take did not clear the pending command");

endmodule

bind line_command_recognizer lcr_checker u_lcr_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rx_valid          (rx.valid),
    .rx_ready          (rx.ready),
    .rx_opcode         (rx.opcode),
    .res_valid         (result.valid),
    .res_ready         (result.ready),
    .res_error_code    (result.error_code),
    .res_taken_command (result.taken_command)
);
